FILE: rtl/core/mprc_pkg.sv
`default_nettype none
package mprc_pkg;
	localparam int MaxRegions = 16;
	localparam int MinRegionBytes = 32;
	localparam logic [32:0] MaxRegionBytes = 33'd1073741824;
	localparam int MaxAccessBytes = 16;
	localparam int IdxW = 4;
	localparam int CntW = 5;
	localparam int AccW = 5;

	typedef enum logic [2:0] {
		FN_CHECK = 3'd0, FN_ADD = 3'd1, FN_REMOVE = 3'd2, FN_UPDATE = 3'd3,
		FN_READ = 3'd4, FN_STATS = 3'd5, FN_CLEAR = 3'd6, FN_NONE = 3'd7
	} func_t;

	typedef enum logic [3:0] {
		ST_OK = 4'd0, ST_UNCOVERED = 4'd1, ST_NOPERM = 4'd2, ST_WRONGCORE = 4'd3,
		ST_FULL = 4'd4, ST_MISALIGNED = 4'd5, ST_BADREGION = 4'd6,
		ST_OVERLAP = 4'd7, ST_BADINDEX = 4'd8
	} status_t;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] len;
		logic [7:0] attr;
	} region_t;

	// per-cell probe: a byte address (scan) or a region range (overlap)
	typedef struct packed {
		logic [32:0] lo;
		logic [32:0] hi;
	} probe_t;

	// what a cell tells the controller about the probe
	typedef struct packed {
		logic hit;
		logic [7:0] attr;
	} hit_t;
endpackage
`default_nettype wire

FILE: rtl/core/mprc_cell.sv
`default_nettype none
module mprc_cell
	import mprc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    live,
	input  wire logic    load,
	input  wire region_t load_data,
	input  wire logic    shift,
	input  wire region_t next_data,
	input  wire probe_t  probe,
	output region_t      data,
	output hit_t         hit
);
	region_t entry_q;
	logic [32:0] end_a;

	always_ff @(posedge clk) begin
		if (load) entry_q <= load_data;
		else if (shift) entry_q <= next_data;
	end

	// range [lo, hi) intersects [base, base+len)
	always_comb begin
		end_a = {1'b0, entry_q.base} + {1'b0, entry_q.len};
		hit.hit = live && (probe.lo < end_a) && ({1'b0, entry_q.base} < probe.hi);
		hit.attr = entry_q.attr;
	end
	assign data = entry_q;
endmodule
`default_nettype wire

FILE: rtl/core/memory_protection_region_checker_core.sv
`default_nettype none
// Memory protection region checker. A row of sixteen region cells holds the
// compacted table; each cell compares its own region against a probe range in
// parallel. A table operation (add, remove, update, read, stats, clear) does
// its work in the cell row in the SCAN state, and its result word is then
// offered in DONE. An access check walks its bytes one per cycle through the
// cell row and stops at the first failing byte. Once the result word is taken
// the block returns to idle, and only there accepts the next word. Remove
// shifts all later cells down together. protection_enable low makes every
// check pass with no counter change. Configuration must be written only while
// the block is idle; the block itself does not enforce this.
module memory_protection_region_checker_core
	import mprc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  func,
	input  wire logic [3:0]  region_index,
	input  wire logic [31:0] address,
	input  wire logic [31:0] length,
	input  wire logic [2:0]  perms,
	input  wire logic        cacheable,
	input  wire logic        bufferable,
	input  wire logic        core_bound,
	input  wire logic [1:0]  core,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       status,
	output logic [3:0]       slot,
	output logic [31:0]      region_base,
	output logic [31:0]      region_length,
	output logic [2:0]       region_perms,
	output logic             region_cacheable,
	output logic             region_bufferable,
	output logic             region_core_bound,
	output logic [1:0]       region_core,
	output logic [4:0]       region_count,
	output logic [31:0]      passed_checks,
	output logic [31:0]      failed_checks
);
	state_t state_q, state_d;
	logic enable_q;
	logic [CntW-1:0] count_q;
	logic [31:0] pass_q, fail_q;
	logic [2:0] func_q;
	logic [IdxW-1:0] idx_q;
	logic [31:0] addr_q, len_q;
	logic [2:0] perms_q;
	logic [1:0] core_q;
	logic [2:0] attr_q;
	logic [AccW-1:0] left_q;
	logic [32:0] byte_q;
	status_t st_q;

	region_t cell_data [MaxRegions];
	hit_t    cell_hit  [MaxRegions];
	logic    cell_load [MaxRegions];
	logic    cell_shift[MaxRegions];
	probe_t  probe;
	region_t new_reg;

	logic accept, finish, any_hit, skip_hit;
	logic [7:0] first_attr;
	status_t vstat;
	logic [32:0] vend;

	assign accept = in_valid && in_ready;
	assign new_reg = '{base: addr_q, len: len_q,
		attr: {core_q, attr_q, perms_q}};

	// probe is a byte for a check, else the region under add/update
	always_comb begin
		if (func_q == FN_CHECK) begin
			probe.lo = byte_q;
			probe.hi = byte_q + 33'd1;
		end else begin
			probe.lo = {1'b0, addr_q};
			probe.hi = {1'b0, addr_q} + {1'b0, len_q};
		end
	end

	genvar g;
	generate
		for (g = 0; g < MaxRegions; g++) begin : g_cell
			mprc_cell u_cell (
				.clk(clk),
				.live(CntW'(g) < count_q),
				.load(cell_load[g]),
				.load_data(new_reg),
				.shift(cell_shift[g]),
				.next_data(g + 1 < MaxRegions ? cell_data[(g+1) % MaxRegions] : cell_data[g]),
				.probe(probe),
				.data(cell_data[g]),
				.hit(cell_hit[g])
			);
		end
	endgenerate

	// first hitting cell; overlap ignores the slot under update
	always_comb begin
		any_hit = 1'b0;
		skip_hit = 1'b0;
		first_attr = '0;
		for (int i = MaxRegions - 1; i >= 0; i--) begin
			if (cell_hit[i].hit) begin
				any_hit = 1'b1;
				first_attr = cell_hit[i].attr;
			end
			if (cell_hit[i].hit && !(func_q == FN_UPDATE && IdxW'(i) == idx_q))
				skip_hit = 1'b1;
		end
	end

	// region validation in priority order
	always_comb begin
		vend = {1'b0, addr_q} + {1'b0, len_q};
		if (addr_q[4:0] != '0) vstat = ST_MISALIGNED;
		else if (len_q == '0) vstat = ST_BADREGION;
		else if (len_q[4:0] != '0) vstat = ST_MISALIGNED;
		else if ({1'b0, len_q} > MaxRegionBytes) vstat = ST_BADREGION;
		else if (vend > 33'h0FFFFFFFF) vstat = ST_BADREGION;
		else if (perms_q == '0) vstat = ST_BADREGION;
		else vstat = ST_OK;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_SCAN;
			S_SCAN: if (finish) state_d = S_DONE;
			S_DONE: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// a check finishes on its last byte or first failing byte, or when protection is off or the length is zero
	always_comb begin
		finish = 1'b1;
		if (func_q == FN_CHECK && enable_q && left_q != '0) begin
			if (any_hit && (first_attr[2:0] & perms_q) == perms_q &&
				!(first_attr[5] && first_attr[7:6] != core_q))
				finish = (left_q == AccW'(1));
		end
	end

	logic wr_ok;
	always_comb begin
		wr_ok = 1'b0;
		if (state_q == S_SCAN) begin
			if (func_q == FN_ADD)
				wr_ok = count_q < CntW'(MaxRegions) && vstat == ST_OK && !skip_hit;
			else if (func_q == FN_UPDATE)
				wr_ok = {1'b0, idx_q} < count_q && vstat == ST_OK && !skip_hit;
		end
		for (int i = 0; i < MaxRegions; i++) begin
			cell_load[i] = wr_ok && ((func_q == FN_ADD && CntW'(i) == count_q) ||
				(func_q == FN_UPDATE && IdxW'(i) == idx_q));
			cell_shift[i] = state_q == S_SCAN && func_q == FN_REMOVE &&
				{1'b0, idx_q} < count_q && IdxW'(i) >= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			enable_q <= 1'b0;
			count_q <= '0;
			pass_q <= '0;
			fail_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) enable_q <= cfg_wdata;
			if (state_q == S_SCAN) begin
				case (func_q)
					FN_CHECK: if (finish && enable_q) begin
						if (st_q == ST_OK && (left_q == '0 || (any_hit &&
							(first_attr[2:0] & perms_q) == perms_q &&
							!(first_attr[5] && first_attr[7:6] != core_q))))
							pass_q <= pass_q + 32'd1;
						else fail_q <= fail_q + 32'd1;
					end
					FN_ADD: if (wr_ok) count_q <= count_q + CntW'(1);
					FN_REMOVE: if ({1'b0, idx_q} < count_q) count_q <= count_q - CntW'(1);
					FN_CLEAR: begin
						pass_q <= '0;
						fail_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// payload and result words
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			idx_q <= region_index;
			addr_q <= address;
			len_q <= length;
			perms_q <= perms;
			core_q <= core;
			attr_q <= {core_bound, bufferable, cacheable};
			left_q <= (length > 32'(MaxAccessBytes)) ? AccW'(MaxAccessBytes) : AccW'(length);
			byte_q <= {1'b0, address};
			st_q <= ST_OK;
			slot <= '0;
			{region_base, region_length, region_perms} <= '0;
			{region_cacheable, region_bufferable, region_core_bound, region_core} <= '0;
		end else if (state_q == S_SCAN) begin
			left_q <= left_q - AccW'(1);
			byte_q <= byte_q + 33'd1;
			case (func_q)
				FN_CHECK: if (enable_q && left_q != '0) begin
					if (!any_hit) st_q <= ST_UNCOVERED;
					else if ((first_attr[2:0] & perms_q) != perms_q) st_q <= ST_NOPERM;
					else if (first_attr[5] && first_attr[7:6] != core_q)
						st_q <= ST_WRONGCORE;
				end
				FN_ADD: begin
					if (count_q >= CntW'(MaxRegions)) st_q <= ST_FULL;
					else if (vstat != ST_OK) st_q <= vstat;
					else if (skip_hit) st_q <= ST_OVERLAP;
					slot <= wr_ok ? count_q[IdxW-1:0] : '0;
				end
				FN_UPDATE: begin
					if ({1'b0, idx_q} >= count_q) st_q <= ST_BADINDEX;
					else if (vstat != ST_OK) st_q <= vstat;
					else if (skip_hit) st_q <= ST_OVERLAP;
				end
				FN_REMOVE: if ({1'b0, idx_q} >= count_q) st_q <= ST_BADINDEX;
				FN_READ: begin
					if ({1'b0, idx_q} >= count_q) st_q <= ST_BADINDEX;
					else begin
						region_base <= cell_data[idx_q].base;
						region_length <= cell_data[idx_q].len;
						region_perms <= cell_data[idx_q].attr[2:0];
						region_cacheable <= cell_data[idx_q].attr[3];
						region_bufferable <= cell_data[idx_q].attr[4];
						region_core_bound <= cell_data[idx_q].attr[5];
						region_core <= cell_data[idx_q].attr[7:6];
					end
				end
				default: ;
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_DONE;
	assign status = st_q;
	assign region_count = count_q;
	assign passed_checks = pass_q;
	assign failed_checks = fail_q;

`ifndef NO_ASSERTIONS
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxRegions)) else $error("count above table size");
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |=> $stable(count_q)) else $error("count moved while idle");
	a_one_ctr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && func_q == FN_CHECK |=> !($past(pass_q) != pass_q &&
		$past(fail_q) != fail_q)) else $error("both counters moved");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped");
`endif
endmodule
`default_nettype wire
